@@ src/itp_pkg.sv @@
// Shared types, character codes and precedence helpers for the infix-to-postfix converter.
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef logic [7:0]       char_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [2:0]       rank_t;

	localparam char_t CH_CARET  = 8'h5E;
	localparam char_t CH_STAR   = 8'h2A;
	localparam char_t CH_SLASH  = 8'h2F;
	localparam char_t CH_PLUS   = 8'h2B;
	localparam char_t CH_MINUS  = 8'h2D;
	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_NUL    = 8'h00;

	// rank codes are precedence + 1, so "no operator" (-1) sits at zero
	localparam rank_t RANK_NONE = 3'd0;
	localparam rank_t RANK_ADD  = 3'd2;
	localparam rank_t RANK_MUL  = 3'd3;
	localparam rank_t RANK_POW  = 3'd4;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNMATCHED = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP,
		STK_CLEAR
	} stk_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPERAND,
		S_PUSH,
		S_CLOSE,
		S_FLUSH
	} state_t;

	typedef struct packed {
		stk_op_t op;
		char_t   data;
	} stk_cmd_t;

	typedef struct packed {
		char_t top;
		char_t second;
		cnt_t  count;
		cnt_t  open_cnt;
	} stk_stat_t;

	function automatic rank_t op_rank(char_t c);
		rank_t r;
		r = RANK_NONE;
		if (c == CH_CARET)
			r = RANK_POW;
		else if (c == CH_STAR || c == CH_SLASH)
			r = RANK_MUL;
		else if (c == CH_PLUS || c == CH_MINUS)
			r = RANK_ADD;
		return r;
	endfunction

	function automatic logic is_operand(char_t c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	// stacked operator leaves before the incoming one is pushed
	function automatic logic pops_before(char_t incoming, char_t stacked);
		rank_t p;
		rank_t pt;
		p  = op_rank(incoming);
		pt = op_rank(stacked);
		return (p < pt) || (p == pt && incoming != CH_CARET);
	endfunction

endpackage

@@ src/itp_cell.sv @@
// One stack cell: holds an entry, takes the one above on push, the one below on pop.
module itp_cell (
	input  logic               clk,
	input  itp_pkg::stk_op_t   op,
	input  itp_pkg::char_t     from_above,
	input  itp_pkg::char_t     from_below,
	output itp_pkg::char_t     data
);

	itp_pkg::char_t data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			itp_pkg::STK_PUSH: begin
				data_q <= from_above;
			end
			itp_pkg::STK_POP: begin
				data_q <= from_below;
			end
			itp_pkg::STK_HOLD, itp_pkg::STK_CLEAR: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

@@ src/itp_stack.sv @@
// Operator stack: a chain of shifting cells plus fill and open-parenthesis counters.
module itp_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  itp_pkg::stk_cmd_t   cmd,
	output itp_pkg::stk_stat_t  stat
);

	itp_pkg::char_t cell_data [itp_pkg::STACK_DEPTH];
	itp_pkg::cnt_t  count_q;
	itp_pkg::cnt_t  open_q;

	// cell 0 is the top of stack
	for (genvar i = 0; i < itp_pkg::STACK_DEPTH; i++) begin : g_cell
		itp_pkg::char_t above;
		itp_pkg::char_t below;

		if (i == 0) begin : g_top
			assign above = cmd.data;
		end else begin : g_mid
			assign above = cell_data[i-1];
		end

		if (i == itp_pkg::STACK_DEPTH - 1) begin : g_bottom
			assign below = cell_data[i];
		end else begin : g_inner
			assign below = cell_data[i+1];
		end

		itp_cell u_cell (
			.clk        (clk),
			.op         (cmd.op),
			.from_above (above),
			.from_below (below),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			open_q  <= '0;
		end else begin
			unique case (cmd.op)
				itp_pkg::STK_PUSH: begin
					count_q <= count_q + itp_pkg::cnt_t'(1);
					if (cmd.data == itp_pkg::CH_LPAREN)
						open_q <= open_q + itp_pkg::cnt_t'(1);
				end
				itp_pkg::STK_POP: begin
					count_q <= count_q - itp_pkg::cnt_t'(1);
					if (cell_data[0] == itp_pkg::CH_LPAREN)
						open_q <= open_q - itp_pkg::cnt_t'(1);
				end
				itp_pkg::STK_CLEAR: begin
					count_q <= '0;
					open_q  <= '0;
				end
				itp_pkg::STK_HOLD: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign stat.top      = cell_data[0];
	assign stat.second   = cell_data[1];
	assign stat.count    = count_q;
	assign stat.open_cnt = open_q;

endmodule

@@ src/infix_to_postfix_converter.sv @@
// Top level of the shunting-yard infix-to-postfix converter: sequencer and result register.
//
// Usage:
//   Input channel (sym_valid / sym_stall, char_in, end_of_expr) takes one infix
//   character per beat. Output channel (res_valid / res_stall) delivers postfix
//   beats: char_out, last_of_run on the final beat caused by an input beat,
//   error_code (overflow / unmatched ')'), expr_done on end-of-expression beats.
// Sequencing:
//   An input beat is taken only in the idle state; each later sequencer step makes
//   at most one stack move and one result: an operand is sent, an operator pops
//   tighter entries and is pushed, ')' pops down to its opener, and the end flag
//   flushes the entries left. The single-port cell chain does at most one push or
//   pop per cycle. Results leave through the result register.
// Stalls:
//   The result register frees as the downstream takes it; while res_stall holds it,
//   steps that send a result wait and sym_stall stays high. Results are never dropped.
// Reset:
//   arst_n clears the stack fill count, the sequencer and the result valid.
//   Stack cell contents are not cleared; only entries below the fill count are read.
module infix_to_postfix_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_stall,
	input  logic [7:0]           char_in,
	input  logic                 end_of_expr,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [7:0]           char_out,
	output logic                 last_of_run,
	output logic [1:0]           error_code,
	output logic                 expr_done
);

	itp_pkg::state_t     state_q;
	itp_pkg::state_t     state_d;
	itp_pkg::char_t      char_q;
	logic                endf_q;
	logic                emitted_q;

	itp_pkg::stk_cmd_t   cmd;
	itp_pkg::stk_stat_t  stat;

	// result register
	logic                res_valid_q;
	itp_pkg::char_t      res_char_q;
	logic                res_last_q;
	itp_pkg::err_t       res_err_q;
	logic                res_done_q;

	// beat being produced this cycle
	logic                emit;
	itp_pkg::char_t      e_char;
	logic                e_last;
	itp_pkg::err_t       e_err;
	logic                e_done;

	logic                emit_ok;
	logic                accept;
	logic                cnt_is_one;
	logic                cnt_is_full;
	logic                op_pops;
	logic                marker;

	itp_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign emit_ok     = !res_valid_q || !res_stall;
	assign accept      = sym_valid && (state_q == itp_pkg::S_IDLE);
	assign sym_stall   = (state_q != itp_pkg::S_IDLE);
	assign cnt_is_one  = (stat.count == itp_pkg::cnt_t'(1));
	assign cnt_is_full = (stat.count == itp_pkg::cnt_t'(itp_pkg::STACK_DEPTH));

	// an operator pops while the top binds tighter, or as tight unless it is '^'; '(' never pops on push
	assign op_pops = (char_q != itp_pkg::CH_LPAREN) && (stat.count != '0) &&
		itp_pkg::pops_before(char_q, stat.top);

	// empty-flush marker: ')' drops its opener as the last entry, end flag set, nothing sent yet
	assign marker = endf_q && cnt_is_one && !emitted_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = itp_pkg::STK_HOLD;
		cmd.data = char_q;
		emit     = 1'b0;
		e_char   = itp_pkg::CH_NUL;
		e_last   = 1'b0;
		e_err    = itp_pkg::ERR_NONE;
		e_done   = 1'b0;

		unique case (state_q)
			itp_pkg::S_IDLE: begin
				if (sym_valid) begin
					if (itp_pkg::is_operand(char_in))
						state_d = itp_pkg::S_OPERAND;
					else if (char_in == itp_pkg::CH_RPAREN)
						state_d = itp_pkg::S_CLOSE;
					else
						state_d = itp_pkg::S_PUSH;
				end
			end

			itp_pkg::S_OPERAND: begin
				if (emit_ok) begin
					emit    = 1'b1;
					e_char  = char_q;
					e_last  = !(endf_q && stat.count != '0);
					e_done  = endf_q && (stat.count == '0);
					state_d = e_last ? itp_pkg::S_IDLE : itp_pkg::S_FLUSH;
				end
			end

			itp_pkg::S_PUSH: begin
				if (op_pops) begin
					if (emit_ok) begin
						emit   = 1'b1;
						e_char = stat.top;
						// last only if no further pop and no end-of-expression flush follow
						e_last = !endf_q &&
							(cnt_is_one || !itp_pkg::pops_before(char_q, stat.second));
						cmd.op = itp_pkg::STK_POP;
					end
				end else if (cnt_is_full) begin
					if (emit_ok) begin
						emit    = 1'b1;
						e_err   = itp_pkg::ERR_OVERFLOW;
						e_last  = 1'b1;
						e_done  = endf_q;
						cmd.op  = itp_pkg::STK_CLEAR;
						state_d = itp_pkg::S_IDLE;
					end
				end else begin
					cmd.op  = itp_pkg::STK_PUSH;
					state_d = endf_q ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
				end
			end

			itp_pkg::S_CLOSE: begin
				if (stat.open_cnt == '0) begin
					if (emit_ok) begin
						emit    = 1'b1;
						e_err   = itp_pkg::ERR_UNMATCHED;
						e_last  = 1'b1;
						e_done  = endf_q;
						cmd.op  = itp_pkg::STK_CLEAR;
						state_d = itp_pkg::S_IDLE;
					end
				end else if (stat.top == itp_pkg::CH_LPAREN) begin
					if (!marker || emit_ok) begin
						cmd.op  = itp_pkg::STK_POP;
						emit    = marker;
						e_last  = marker;
						e_done  = marker;
						state_d = (endf_q && !cnt_is_one) ? itp_pkg::S_FLUSH :
							itp_pkg::S_IDLE;
					end
				end else if (emit_ok) begin
					emit   = 1'b1;
					e_char = stat.top;
					e_last = (stat.second == itp_pkg::CH_LPAREN) &&
						(!endf_q || stat.count == itp_pkg::cnt_t'(2));
					e_done = endf_q && e_last;
					cmd.op = itp_pkg::STK_POP;
				end
			end

			itp_pkg::S_FLUSH: begin
				if (emit_ok) begin
					emit   = 1'b1;
					e_char = stat.top;
					e_last = cnt_is_one;
					e_done = 1'b1;
					cmd.op = itp_pkg::STK_POP;
					if (cnt_is_one)
						state_d = itp_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = itp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itp_pkg::S_IDLE;
			emitted_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				emitted_q <= 1'b0;
			else if (emit)
				emitted_q <= 1'b1;
			if (emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= char_in;
			endf_q <= end_of_expr;
		end
		if (emit) begin
			res_char_q <= e_char;
			res_last_q <= e_last;
			res_err_q  <= e_err;
			res_done_q <= e_done;
		end
	end

	assign res_valid   = res_valid_q;
	assign char_out    = res_char_q;
	assign last_of_run = res_last_q;
	assign error_code  = res_err_q;
	assign expr_done   = res_done_q;

	// every '(' counted is also a stacked entry
	a_open_within_count: assert property (@(posedge clk) disable iff (!arst_n)
		stat.open_cnt <= stat.count)
		else $error("open parenthesis count above stack fill");

	// a taken input beat always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != itp_pkg::S_IDLE)
		else $error("input beat taken but sequencer stayed idle");

	// error beats end their run and leave an empty stack
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && e_err != itp_pkg::ERR_NONE |-> e_last ##1 stat.count == '0)
		else $error("error beat not last or stack not cleared");

	// the stack never grows past its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == itp_pkg::STK_PUSH |-> !cnt_is_full)
		else $error("push onto a full stack");

endmodule

@@ verif/infix_to_postfix_converter_tb.sv @@
// Self-checking testbench for the infix-to-postfix converter: directed, overflow and random runs.
module infix_to_postfix_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one postfix beat as the output channel carries it
	typedef struct packed {
		itp_pkg::char_t ch;
		logic           last;
		itp_pkg::err_t  err;
		logic           done;
	} postfix_beat_t;

	// directed table row; typed rows carry their single result, the rest go to the predictor
	typedef struct packed {
		itp_pkg::char_t ch;
		logic           eoe;
		logic           typed;
		postfix_beat_t  want;
	} stim_row_t;

	localparam postfix_beat_t NO_BEAT = '{itp_pkg::CH_NUL, 1'b0, itp_pkg::ERR_NONE, 1'b0};
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_BEATS = 24;
	localparam int DIR_ROWS = 26;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       sym_valid = 1'b0;
	logic       sym_stall;
	logic [7:0] char_in = 8'h00;
	logic       end_of_expr = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] char_out;
	logic       last_of_run;
	logic [1:0] error_code;
	logic       expr_done;

	// idle mix, changed per phase
	int send_idle_pct = 0;
	int stall_pct = 0;

	// run bookkeeping
	int in_beats = 0;
	int out_beats = 0;
	int mismatches = 0;
	int overflow_seen = 0;
	int unmatched_seen = 0;

	// shadow operator stack
	itp_pkg::char_t op_mem [itp_pkg::STACK_DEPTH];
	int             op_fill = 0;
	postfix_beat_t  step_beats[$];   // results of the beat just taken
	postfix_beat_t  postfix_q[$];    // results still owed by the block
	itp_pkg::char_t expr_q[$];       // characters of the sequence being sent

	// directed table: reset state, every operand class and operator, the extremes
	// of char_in, both associativities, odd operators, and the unmatched ')' error
	stim_row_t dir_tab [DIR_ROWS] = '{
		// ')' on empty stack
		'{")",   1'b0, 1'b1, '{itp_pkg::CH_NUL, 1'b1, itp_pkg::ERR_UNMATCHED, 1'b0}},
		'{"a",   1'b0, 1'b1, '{"a",    1'b1, itp_pkg::ERR_NONE,      1'b0}},
		'{"+",   1'b0, 1'b0, NO_BEAT},
		'{"b",   1'b0, 1'b0, NO_BEAT},
		'{"*",   1'b0, 1'b0, NO_BEAT},
		'{"c",   1'b0, 1'b0, NO_BEAT},
		'{"^",   1'b0, 1'b0, NO_BEAT},
		'{"2",   1'b0, 1'b0, NO_BEAT},
		'{"^",   1'b0, 1'b0, NO_BEAT},   // right-assoc: no pop on equal rank
		'{"3",   1'b1, 1'b0, NO_BEAT},   // flush four operators
		'{"(",   1'b1, 1'b0, NO_BEAT},   // lone opener flushed out
		'{8'h00, 1'b1, 1'b0, NO_BEAT},   // NUL is an operator
		'{" ",   1'b0, 1'b0, NO_BEAT},
		'{"(",   1'b0, 1'b0, NO_BEAT},
		'{"A",   1'b0, 1'b0, NO_BEAT},
		'{"-",   1'b0, 1'b0, NO_BEAT},
		'{"Z",   1'b0, 1'b0, NO_BEAT},
		'{"/",   1'b0, 1'b0, NO_BEAT},
		'{"9",   1'b0, 1'b0, NO_BEAT},
		'{")",   1'b0, 1'b0, NO_BEAT},   // pops down to the opener
		'{8'hFF, 1'b0, 1'b0, NO_BEAT},   // odd operator pops the stacked space
		'{"0",   1'b1, 1'b0, NO_BEAT},
		'{"(",   1'b0, 1'b0, NO_BEAT},
		// empty flush marker
		'{")",   1'b1, 1'b1, '{itp_pkg::CH_NUL, 1'b1, itp_pkg::ERR_NONE,      1'b1}},
		'{")",   1'b1, 1'b1, '{itp_pkg::CH_NUL, 1'b1, itp_pkg::ERR_UNMATCHED, 1'b1}},
		'{"z",   1'b1, 1'b1, '{"z",    1'b1, itp_pkg::ERR_NONE,      1'b1}}
	};

	infix_to_postfix_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.char_in     (char_in),
		.end_of_expr (end_of_expr),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.char_out    (char_out),
		.last_of_run (last_of_run),
		.error_code  (error_code),
		.expr_done   (expr_done)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// precedence; anything not listed (stacked '(' too) ranks -1
	function automatic int bind_level(itp_pkg::char_t c);
		case (c)
			itp_pkg::CH_CARET:                   return 3;
			itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return 2;
			itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
			default:                             return -1;
		endcase
	endfunction

	function automatic void add_beat(itp_pkg::char_t c, itp_pkg::err_t e, logic d);
		postfix_beat_t b;
		b.ch   = c;
		b.last = 1'b0;
		b.err  = e;
		b.done = d;
		step_beats.push_back(b);
	endfunction

	// push, or report overflow and clear when full
	function automatic void push_op(itp_pkg::char_t c, logic eoe);
		if (op_fill >= itp_pkg::STACK_DEPTH) begin
			add_beat(itp_pkg::CH_NUL, itp_pkg::ERR_OVERFLOW, eoe);
			op_fill = 0;
		end else begin
			op_mem[op_fill] = c;
			op_fill++;
		end
	endfunction

	// shunting-yard step for one infix char; fills step_beats
	function automatic void shunt_char(itp_pkg::char_t c, logic eoe);
		logic found;
		int   p;
		step_beats.delete();
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
			add_beat(c, itp_pkg::ERR_NONE, 1'b0);
		end else if (c == itp_pkg::CH_LPAREN) begin
			push_op(c, eoe);
		end else if (c == itp_pkg::CH_RPAREN) begin
			found = 1'b0;
			for (int i = 0; i < op_fill; i++)
				if (op_mem[i] == itp_pkg::CH_LPAREN)
					found = 1'b1;
			if (!found) begin
				add_beat(itp_pkg::CH_NUL, itp_pkg::ERR_UNMATCHED, eoe);
				op_fill = 0;
			end else begin
				while (op_fill > 0 && op_mem[op_fill-1] != itp_pkg::CH_LPAREN) begin
					op_fill--;
					add_beat(op_mem[op_fill], itp_pkg::ERR_NONE, 1'b0);
				end
				if (op_fill > 0)
					op_fill--;
			end
		end else begin
			p = bind_level(c);
			// pop tighter ops; equal rank pops unless incoming is '^'
			while (op_fill > 0 && (p < bind_level(op_mem[op_fill-1]) ||
					(p == bind_level(op_mem[op_fill-1]) && c != itp_pkg::CH_CARET))) begin
				op_fill--;
				add_beat(op_mem[op_fill], itp_pkg::ERR_NONE, 1'b0);
			end
			push_op(c, eoe);
		end
		if (eoe) begin
			while (op_fill > 0) begin
				op_fill--;
				add_beat(op_mem[op_fill], itp_pkg::ERR_NONE, 1'b1);
			end
			if (step_beats.size() == 0)
				add_beat(itp_pkg::CH_NUL, itp_pkg::ERR_NONE, 1'b1);
			step_beats[step_beats.size()-1].done = 1'b1;
		end
		if (step_beats.size() > 0)
			step_beats[step_beats.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// present one beat after a random gap and hold it until taken; then predict
	task automatic feed(input itp_pkg::char_t c, input logic eoe, input logic typed,
			input postfix_beat_t want);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid   <= 1'b1;
		char_in     <= c;
		end_of_expr <= eoe;
		@(posedge clk);
		while (sym_stall)
			@(posedge clk);
		in_beats++;
		shunt_char(c, eoe);
		if (typed)
			postfix_q.push_back(want);
		else
			foreach (step_beats[i])
				postfix_q.push_back(step_beats[i]);
	endtask

	// drop valid and wait until every owed result has come out
	task automatic settle();
		sym_valid <= 1'b0;
		do
			@(posedge clk);
		while (postfix_q.size() != 0);
	endtask

	// random well-formed infix expression into expr_q
	function automatic void build_expr(int lvl);
		string ops;
		int    terms;
		ops   = "+-*/^";
		terms = $urandom_range(1, 4);
		for (int t = 0; t < terms; t++) begin
			if (t > 0)
				expr_q.push_back(ops[$urandom_range(0, 4)]);
			if (lvl < 4 && $urandom_range(0, 3) == 0) begin
				expr_q.push_back(itp_pkg::CH_LPAREN);
				build_expr(lvl + 1);
				expr_q.push_back(itp_pkg::CH_RPAREN);
			end else begin
				case ($urandom_range(0, 2))
					0:       expr_q.push_back(itp_pkg::char_t'("a" + $urandom_range(0, 25)));
					1:       expr_q.push_back(itp_pkg::char_t'("A" + $urandom_range(0, 25)));
					default: expr_q.push_back(itp_pkg::char_t'("0" + $urandom_range(0, 9)));
				endcase
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall, compare each taken beat with the oldest owed one
	// ------------------------------------------------------------------

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		postfix_beat_t want;
		if (res_valid && !res_stall) begin
			out_beats++;
			if (error_code == itp_pkg::ERR_OVERFLOW)
				overflow_seen++;
			if (error_code == itp_pkg::ERR_UNMATCHED)
				unmatched_seen++;
			if (postfix_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none, actual char %0h err %0d",
					$time, char_out, error_code);
			end else begin
				want = postfix_q.pop_front();
				compare_field("char_out", want.ch, char_out);
				compare_field("last_of_run", want.last, last_of_run);
				compare_field("error_code", want.err, error_code);
				compare_field("expr_done", want.done, expr_done);
			end
		end
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: cycles with no beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sym_valid && !sym_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired, %0d result beats still owed", $time, postfix_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int start;
		int pos;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (dir_tab[i])
			feed(dir_tab[i].ch, dir_tab[i].eoe, dir_tab[i].typed, dir_tab[i].want);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 67; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 67; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase

			// overflow runs: 33 openers, then a chain of right-assoc carets
			if (ph == 0) begin
				repeat (itp_pkg::STACK_DEPTH + 1)
					feed(itp_pkg::CH_LPAREN, 1'b0, 1'b0, NO_BEAT);
				feed("q", 1'b1, 1'b0, NO_BEAT);
			end
			if (ph == 2) begin
				repeat (itp_pkg::STACK_DEPTH + 1)
					feed(itp_pkg::CH_CARET, 1'b0, 1'b0, NO_BEAT);
				feed(itp_pkg::CH_CARET, 1'b1, 1'b0, NO_BEAT);
			end

			start = in_beats;
			while (in_beats - start < PHASE_BEATS) begin
				expr_q.delete();
				if ($urandom_range(0, 9) == 0) begin
					// noise: any byte, end flag at random
					n = $urandom_range(3, 10);
					repeat (n)
						feed(itp_pkg::char_t'($urandom_range(0, 255)),
							1'($urandom_range(0, 3) == 0), 1'b0, NO_BEAT);
				end else begin
					build_expr(0);
					// some sequences get broken: a char lost or a stray one added
					if ($urandom_range(0, 4) == 0) begin
						pos = $urandom_range(0, expr_q.size() - 1);
						case ($urandom_range(0, 3))
							0:       expr_q.delete(pos);
							1:       expr_q.insert(pos, itp_pkg::CH_RPAREN);
							2:       expr_q.insert(pos, itp_pkg::CH_LPAREN);
							default: expr_q.insert(pos,
								itp_pkg::char_t'($urandom_range(0, 255)));
						endcase
					end
					foreach (expr_q[i])
						feed(expr_q[i], 1'(i == expr_q.size() - 1), 1'b0, NO_BEAT);
				end
			end
			settle();
		end

		// room for stray beats past the longest flush
		repeat (3 * (itp_pkg::STACK_DEPTH + 1)) @(posedge clk);

		$display("Run: %0d infix beats in, %0d postfix beats out, over four idle/stall mixes.",
			in_beats, out_beats);
		$display("Errors seen: %0d stack overflow, %0d unmatched close paren.",
			overflow_seen, unmatched_seen);
		if (mismatches == 0 && postfix_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d result beats never arrived", mismatches,
				postfix_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
